### sv/conv3x3_clamped_u8_top_macros.svh
// Assertion macros shared by the conv3x3_clamped_u8_top checker.
`ifndef CONV3X3_CLAMPED_U8_TOP_MACROS_SVH
`define CONV3X3_CLAMPED_U8_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define C3X3_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define C3X3_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/c3x3_pkg.sv
// Shared constants and types of the 3x3 clamped convolution block.
`timescale 1ns / 1ps
package c3x3_pkg;

  // Default geometry and coefficient format
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_COEF_WIDTH = 16;
  localparam int FRAC_BITS      = 8;
  localparam int PIX_BITS       = 8;
  localparam logic [PIX_BITS-1:0] PIX_MAX = 8'd255;

  // Register file layout (64-bit registers at 8-byte spacing)
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_ADDR_W   = 6;
  localparam int CFG_IDX_LSB  = 3;
  localparam int WIDTH_BITS   = 12;
  localparam int HEIGHT_BITS  = 13;
  localparam int KROW_BITS    = 48;
  localparam logic [WIDTH_BITS-1:0]  WIDTH_RST  = 12'd640;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RST = 13'd480;

  typedef enum logic [CFG_ADDR_W-CFG_IDX_LSB-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_KTOP   = 3'd2,
    CFG_KMID   = 3'd3,
    CFG_KBOT   = 3'd4
  } cfg_idx_t;

  // One window column: pixels from two rows above, one row above, current row
  typedef struct packed {
    logic [PIX_BITS-1:0] top;
    logic [PIX_BITS-1:0] mid;
    logic [PIX_BITS-1:0] bot;
  } pix_col_t;

  // Control handed to every cell of the window chain
  typedef struct packed {
    logic en;     // pipeline advances this cycle
    logic shift;  // a new column enters the window
  } cell_ctl_t;

endpackage

### sv/c3x3_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module c3x3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/c3x3_cell.sv
// One window column cell: holds three pixels, weights them, sums the column.
`timescale 1ns / 1ps
module c3x3_cell import c3x3_pkg::*; #(
  parameter int COEF_WIDTH = DEF_COEF_WIDTH
) (
  input  logic                         clk,
  input  cell_ctl_t                    ctl,
  input  pix_col_t                     col_in,
  input  logic signed [COEF_WIDTH-1:0] coef_top,
  input  logic signed [COEF_WIDTH-1:0] coef_mid,
  input  logic signed [COEF_WIDTH-1:0] coef_bot,
  output pix_col_t                     col_out,
  output logic signed [COEF_WIDTH+10:0] col_sum
);

  localparam int PW = COEF_WIDTH + PIX_BITS + 1;  // product width
  localparam int SW = PW + 2;                     // column sum width

  pix_col_t               pix_r;
  logic signed [PW-1:0]   prod_top_r, prod_mid_r, prod_bot_r;
  logic signed [PW-1:0]   prod_top_nxt, prod_mid_nxt, prod_bot_nxt;
  logic signed [SW-1:0]   sum_r, sum_nxt;

  // pixel times coefficient, pixel taken as a positive signed value
  assign prod_top_nxt = PW'(signed'({1'b0, pix_r.top})) * PW'(coef_top);
  assign prod_mid_nxt = PW'(signed'({1'b0, pix_r.mid})) * PW'(coef_mid);
  assign prod_bot_nxt = PW'(signed'({1'b0, pix_r.bot})) * PW'(coef_bot);

  assign sum_nxt = SW'(prod_top_r) + SW'(prod_mid_r) + SW'(prod_bot_r);

  // shift column, then products, then column sum, all on the pipeline enable
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.shift) begin
        pix_r <= col_in;
      end
      prod_top_r <= prod_top_nxt;
      prod_mid_r <= prod_mid_nxt;
      prod_bot_r <= prod_bot_nxt;
      sum_r      <= sum_nxt;
    end
  end

  assign col_out = pix_r;
  assign col_sum = sum_r;

endmodule

### sv/conv3x3_clamped_u8_top.sv
// Top level of the streaming 3x3 convolution with clamp to 8 bits.
//
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------------
//  in      | in_valid/in_ready  | in_pixel, in_frame_start
//  out     | out_valid/out_ready| out_value, out_col, out_row, out_frame_last
//  cfg     | APB (psel/penable) | paddr, pwdata, prdata (64-bit registers)
//
//  One pixel per clock while the skid entry is free; each pixel passes line buffer
//  read, window shift, products, column sums, total and clamp to the result register.
//  Throughput is set by the single line buffer RAM, one read and one write a cycle.
//  rst_n (synchronous) clears counters, valid flags and configuration registers;
//  line buffers are not cleared. A two-entry output buffer absorbs out_ready stalls;
//  in_ready drops only when both entries hold results, and then the whole pipe freezes.
`timescale 1ns / 1ps
module conv3x3_clamped_u8_top import c3x3_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int COEF_WIDTH = DEF_COEF_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input item channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [PIX_BITS-1:0]            in_pixel,
  input  logic                           in_frame_start,
  // result item channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [PIX_BITS-1:0]            out_value,
  output logic [$clog2(MAX_WIDTH)-1:0]   out_col,
  output logic [$clog2(MAX_HEIGHT)-1:0]  out_row,
  output logic                           out_frame_last,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [CFG_ADDR_W-1:0]          paddr,
  input  logic [CFG_DATA_W-1:0]          pwdata,
  output logic [CFG_DATA_W-1:0]          prdata,
  output logic                           pready
);

  localparam int CB = $clog2(MAX_WIDTH);        // column index bits
  localparam int RB = $clog2(MAX_HEIGHT);       // row index bits
  localparam int EW = $clog2(MAX_WIDTH + 1);    // effective width bits
  localparam int EH = $clog2(MAX_HEIGHT + 1);   // effective height bits
  localparam int KW = 3 * COEF_WIDTH;           // bits of three coefficients
  localparam int SW = COEF_WIDTH + PIX_BITS + 3; // column sum width
  localparam int TW = SW + 2;                   // window sum width
  localparam int LW = 2 * PIX_BITS;             // line buffer word: two rows

  typedef struct packed {
    logic          prod;   // item gives a result
    logic [CB-1:0] col;
    logic [RB-1:0] row;
    logic          last;
  } meta_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [WIDTH_BITS-1:0]  width_r;
  logic [HEIGHT_BITS-1:0] height_r;
  logic [KROW_BITS-1:0]   ktop_r, kmid_r, kbot_r;
  logic                   cfg_wr;
  cfg_idx_t               cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = cfg_idx_t'(paddr[CFG_ADDR_W-1:CFG_IDX_LSB]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      ktop_r   <= '0;
      kmid_r   <= '0;
      kbot_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        CFG_WIDTH:  width_r  <= pwdata[WIDTH_BITS-1:0];
        CFG_HEIGHT: height_r <= pwdata[HEIGHT_BITS-1:0];
        CFG_KTOP:   ktop_r   <= pwdata[KROW_BITS-1:0];
        CFG_KMID:   kmid_r   <= pwdata[KROW_BITS-1:0];
        CFG_KBOT:   kbot_r   <= pwdata[KROW_BITS-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      CFG_WIDTH:  prdata = CFG_DATA_W'(width_r);
      CFG_HEIGHT: prdata = CFG_DATA_W'(height_r);
      CFG_KTOP:   prdata = CFG_DATA_W'(ktop_r);
      CFG_KMID:   prdata = CFG_DATA_W'(kmid_r);
      CFG_KBOT:   prdata = CFG_DATA_W'(kbot_r);
      default:    prdata = '0;
    endcase
  end

  // effective geometry, saturated to 3..MAX
  logic [EW-1:0] eff_w;
  logic [EH-1:0] eff_h;

  always_comb begin
    if (32'(width_r) < 32'd3) begin
      eff_w = EW'(3);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(width_r);
    end
    if (32'(height_r) < 32'd3) begin
      eff_h = EH'(3);
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      eff_h = EH'(MAX_HEIGHT);
    end else begin
      eff_h = EH'(height_r);
    end
  end

  // coefficient unpack; bits past the register read as zero
  logic [KW-1:0] ktop_ext, kmid_ext, kbot_ext;

  generate
    if (KW > KROW_BITS) begin : g_kpad
      assign ktop_ext = {{(KW-KROW_BITS){1'b0}}, ktop_r};
      assign kmid_ext = {{(KW-KROW_BITS){1'b0}}, kmid_r};
      assign kbot_ext = {{(KW-KROW_BITS){1'b0}}, kbot_r};
    end else begin : g_ktrim
      assign ktop_ext = ktop_r[KW-1:0];
      assign kmid_ext = kmid_r[KW-1:0];
      assign kbot_ext = kbot_r[KW-1:0];
    end
  endgenerate

  // ---------------------------------------------------------------------------
  // Stage 0: position counters and line buffer read
  // ---------------------------------------------------------------------------
  logic           en;         // pipeline advances
  logic           accept;
  logic [CB-1:0]  col_r, col0;
  logic [RB-1:0]  row_r, row0;
  logic [EW-1:0]  col_inc;
  logic [EH-1:0]  row_inc;
  logic [CB-1:0]  col_nxt;
  logic [RB-1:0]  row_nxt;
  meta_t          meta0;

  assign accept = in_valid && in_ready;
  assign col0   = in_frame_start ? '0 : col_r;
  assign row0   = in_frame_start ? '0 : row_r;
  assign col_inc = EW'(col0) + EW'(1);
  assign row_inc = EH'(row0) + EH'(1);

  // raster advance with wrap at the effective width and height
  always_comb begin
    col_nxt = col_inc[CB-1:0];
    row_nxt = row0;
    if (col_inc >= eff_w) begin
      col_nxt = '0;
      row_nxt = (row_inc >= eff_h) ? '0 : row_inc[RB-1:0];
    end
  end

  always_comb begin
    meta0.prod = (col0 >= CB'(2)) && (EW'(col0) < eff_w) &&
                 (row0 >= RB'(2)) && (EH'(row0) < eff_h);
    meta0.col  = col0 - CB'(1);
    meta0.row  = row0 - RB'(1);
    meta0.last = (EW'(col0) == eff_w - EW'(1)) && (EH'(row0) == eff_h - EH'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line buffer data, write back with the row shift
  // ---------------------------------------------------------------------------
  logic                s1_v_r;
  logic [PIX_BITS-1:0] s1_px_r;
  logic [CB-1:0]       s1_addr_r;
  meta_t               s1_meta_r;
  logic                byp_r;
  logic [LW-1:0]       byp_data_r;
  logic [LW-1:0]       ram_q, pair, wr_pair;
  logic                ram_we;

  // same column written by the item ahead: take its write data
  assign pair    = byp_r ? byp_data_r : ram_q;
  assign wr_pair = {s1_px_r, pair[LW-1:PIX_BITS]};
  assign ram_we  = en && s1_v_r;

  c3x3_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr_r),
    .wdata (wr_pair),
    .re    (en),
    .raddr (col0),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r         <= 1'b0;
      s1_meta_r.prod <= 1'b0;
      byp_r          <= 1'b0;
    end else if (en) begin
      s1_v_r         <= accept;
      s1_meta_r.prod <= accept && meta0.prod;
      byp_r          <= s1_v_r && (s1_addr_r == col0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_px_r        <= in_pixel;
      s1_addr_r      <= col0;
      s1_meta_r.col  <= meta0.col;
      s1_meta_r.row  <= meta0.row;
      s1_meta_r.last <= meta0.last;
      byp_data_r     <= wr_pair;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 2..4: window chain of column cells (window, products, column sums)
  // ---------------------------------------------------------------------------
  cell_ctl_t                  ctl;
  pix_col_t                   new_col;
  pix_col_t                   cell_pix [3];
  logic signed [SW-1:0]       cell_sum [3];

  assign ctl.en      = en;
  assign ctl.shift   = s1_v_r;
  assign new_col.top = pair[PIX_BITS-1:0];
  assign new_col.mid = pair[LW-1:PIX_BITS];
  assign new_col.bot = s1_px_r;

  // cell 0 holds the left column, cell 2 takes the new column
  generate
    for (genvar k = 0; k < 3; k++) begin : g_cell
      c3x3_cell #(
        .COEF_WIDTH (COEF_WIDTH)
      ) u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .col_in   ((k == 2) ? new_col : cell_pix[(k+1) % 3]),
        .coef_top (signed'(ktop_ext[k*COEF_WIDTH +: COEF_WIDTH])),
        .coef_mid (signed'(kmid_ext[k*COEF_WIDTH +: COEF_WIDTH])),
        .coef_bot (signed'(kbot_ext[k*COEF_WIDTH +: COEF_WIDTH])),
        .col_out  (cell_pix[k]),
        .col_sum  (cell_sum[k])
      );
    end
  endgenerate

  // position info travels alongside: index 0 is stage 2, index 3 is stage 5
  meta_t meta_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        meta_r[i] <= '0;
      end
    end else if (en) begin
      meta_r[0] <= s1_meta_r;
      for (int i = 1; i < 4; i++) begin
        meta_r[i] <= meta_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: window total, then clamp into the output buffer
  // ---------------------------------------------------------------------------
  logic signed [TW-1:0] total_r, total_nxt;
  logic [PIX_BITS-1:0]  clamped;

  assign total_nxt = TW'(cell_sum[0]) + TW'(cell_sum[1]) + TW'(cell_sum[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      total_r <= total_nxt;
    end
  end

  // negative to zero, integer part above 255 to 255
  always_comb begin
    if (total_r[TW-1]) begin
      clamped = '0;
    end else if (|total_r[TW-2:FRAC_BITS+PIX_BITS]) begin
      clamped = PIX_MAX;
    end else begin
      clamped = total_r[FRAC_BITS+PIX_BITS-1:FRAC_BITS];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register plus skid entry
  // ---------------------------------------------------------------------------
  logic                out_v_r, skid_v_r;
  logic [PIX_BITS-1:0] out_val_r, skid_val_r;
  meta_t               out_meta_r, skid_meta_r;
  logic                push;
  meta_t               push_meta;

  assign en        = !skid_v_r;
  assign in_ready  = en;
  assign push      = en && meta_r[3].prod;
  assign push_meta = meta_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ready) begin
      out_v_r  <= skid_v_r || push;
      skid_v_r <= 1'b0;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_val_r  <= skid_val_r;
        out_meta_r <= skid_meta_r;
      end else begin
        out_val_r  <= clamped;
        out_meta_r <= push_meta;
      end
    end else if (push) begin
      skid_val_r  <= clamped;
      skid_meta_r <= push_meta;
    end
  end

  assign out_valid      = out_v_r;
  assign out_value      = out_val_r;
  assign out_col        = out_meta_r.col;
  assign out_row        = out_meta_r.row;
  assign out_frame_last = out_meta_r.last;

endmodule

### sv/c3x3_chk.sv
// Port-level checker for conv3x3_clamped_u8_top, with its bind.
`timescale 1ns / 1ps
`include "conv3x3_clamped_u8_top_macros.svh"
module c3x3_chk import c3x3_pkg::*; #(
  parameter int COL_W = $clog2(DEF_MAX_WIDTH),
  parameter int ROW_W = $clog2(DEF_MAX_HEIGHT)
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [PIX_BITS-1:0] out_value,
  input logic [COL_W-1:0]    out_col,
  input logic [ROW_W-1:0]    out_row,
  input logic                out_frame_last
);

  // a stalled result stays offered
  `C3X3_CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result lost under stall")

  // a stalled result keeps its payload
  `C3X3_CHK_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_value) && $stable(out_col) && $stable(out_row) && $stable(out_frame_last), "result changed under stall")

  // results only come from interior positions
  `C3X3_CHK_NOW(a_out_interior, out_valid, out_col != 0 && out_row != 0, "border position in result")

  // input backpressure only when the output register is occupied
  `C3X3_CHK_NOW(a_ready_drop, !in_ready, out_valid, "input stalled with empty output")

endmodule

bind conv3x3_clamped_u8_top c3x3_chk #(
  .COL_W ($clog2(MAX_WIDTH)),
  .ROW_W ($clog2(MAX_HEIGHT))
) u_c3x3_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_value      (out_value),
  .out_col        (out_col),
  .out_row        (out_row),
  .out_frame_last (out_frame_last)
);
